/* hdl/adsr_pkg.sv */
// ----------------------------------------------------------------------------
// adsr_pkg
// Shared types and constants for the linear ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_pkg;

  // Level format: 1.16 fixed point, full scale is 1.0
  localparam int unsigned LEVEL_W    = 17;
  localparam int unsigned FRAC_W     = 16;
  localparam int unsigned PHASE_W    = 3;
  localparam int unsigned CFG_TICK_W = 16;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned TICK_BITS_DEF = 16;

  localparam logic [LEVEL_W-1:0] FULL_SCALE = LEVEL_W'(65536);

  // Ramp fraction is at most 1.0, so the quotient needs FRAC_W+1 bits
  localparam int unsigned QUO_W     = FRAC_W + 1;
  localparam int unsigned DIV_STEPS = QUO_W;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_ATTACK  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DECAY   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RELEASE = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SUSTAIN = 2'd3;

  typedef enum logic [PHASE_W-1:0] {
    PH_OFF     = 3'd0,
    PH_ATTACK  = 3'd1,
    PH_DECAY   = 3'd2,
    PH_SUSTAIN = 3'd3,
    PH_RELEASE = 3'd4
  } phase_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_MUL,
    ST_ADD,
    ST_FIN
  } state_t;

endpackage

`default_nettype wire

/* hdl/adsr_envelope_generator.sv */
// ----------------------------------------------------------------------------
// adsr_envelope_generator
// Linear ADSR envelope: one gate sample in, one 1.16 level and phase out.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carries one sample tick with its gate level. Each
//   transaction produces exactly one result on out_valid/out_ready (level in
//   1.16, 65536 = 1.0, and the phase after the step).
//   cfg_valid/cfg_ready writes attack, decay and release lengths (ticks) and
//   the sustain level; write only while the block is idle.
// Timing:
//   A step that lands on a ramp runs a 17-step restoring divider (one
//   quotient bit per cycle), then one multiply and one add; out_valid
//   rises with in_ready back high in that same cycle, and no new tick is
//   taken before that. Steps with no ramp (off, sustain, phase end) go from
//   accept straight to the finish state, then load the output register.
//   The divider sets the rate.
// Reset (rst_n, synchronous): phase off, level 0, all lengths 0, sustain
//   at full scale, no result pending.
// Stall: the result sits in an output register; the block takes the next
//   tick while it waits, and holds the following result until it drains.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator #(
  parameter int unsigned TICK_BITS = adsr_pkg::TICK_BITS_DEF
) (
  input  wire logic                               clk,
  input  wire logic                               rst_n,
  // configuration
  input  wire logic                               cfg_valid,
  output logic                                    cfg_ready,
  input  wire logic [adsr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [adsr_pkg::CFG_DATA_W-1:0]    cfg_data,
  // input ticks
  input  wire logic                               in_valid,
  output logic                                    in_ready,
  input  wire logic                               in_gate,
  // results
  output logic                                    out_valid,
  input  wire logic                               out_ready,
  output logic [adsr_pkg::LEVEL_W-1:0]            out_level,
  output logic [adsr_pkg::PHASE_W-1:0]            out_phase
);

  import adsr_pkg::*;

  localparam int unsigned REM_W = TICK_BITS + 1;
  localparam int unsigned PROD_W = 2 * (LEVEL_W + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_STEPS - 1);

  // Configuration registers
  logic [CFG_TICK_W-1:0] attack_r, decay_r, release_r;
  logic [LEVEL_W-1:0]    sustain_r;

  // Envelope state
  phase_t                phase_r;
  logic [TICK_BITS-1:0]  el_r;
  logic [LEVEL_W-1:0]    start_r;
  logic [LEVEL_W-1:0]    last_r;

  // Sequencer and datapath
  state_t                state_r, state_nxt;
  logic [CNT_W-1:0]      cnt_r;
  logic [REM_W-1:0]      rem_r;
  logic [QUO_W-1:0]      quo_r;
  logic [TICK_BITS-1:0]  dur_r;
  logic [LEVEL_W-1:0]    from_r, to_r;
  logic signed [PROD_W-1:0] prod_r;
  logic [LEVEL_W-1:0]    lvl_r;

  // Output register
  logic                  out_valid_r;
  logic [LEVEL_W-1:0]    out_level_r;
  phase_t                out_phase_r;

  logic in_acc, out_free;
  assign in_acc   = in_valid && in_ready;
  assign out_free = !out_valid_r || out_ready;

  // --------------------------------------------------------------------------
  // Step decode: gate transitions, phase end and ramp setup
  // --------------------------------------------------------------------------
  logic [31:0]          att_ext, dec_ext, rel_ext;
  logic [TICK_BITS-1:0] dur_att, dur_dec, dur_rel;
  logic [LEVEL_W-1:0]   sust_eff;
  phase_t               ph_a, ph_n;
  logic [TICK_BITS-1:0] el_a, el_n, el_inc;
  logic [LEVEL_W-1:0]   start_a;
  logic [TICK_BITS-1:0] dur_sel;
  logic                 ramp_go;
  logic [LEVEL_W-1:0]   lvl_direct, from_n, to_n;

  assign att_ext  = 32'(attack_r);
  assign dec_ext  = 32'(decay_r);
  assign rel_ext  = 32'(release_r);
  assign dur_att  = att_ext[TICK_BITS-1:0];
  assign dur_dec  = dec_ext[TICK_BITS-1:0];
  assign dur_rel  = rel_ext[TICK_BITS-1:0];
  assign sust_eff = (sustain_r > FULL_SCALE) ? FULL_SCALE : sustain_r;

  always_comb begin
    ph_a    = phase_r;
    el_a    = el_r;
    start_a = start_r;
    if (in_gate && (phase_r == PH_OFF || phase_r == PH_RELEASE)) begin
      ph_a    = PH_ATTACK;
      el_a    = '0;
      start_a = last_r;
    end
    if (!in_gate && (phase_r == PH_ATTACK || phase_r == PH_DECAY ||
                     phase_r == PH_SUSTAIN)) begin
      ph_a    = PH_RELEASE;
      el_a    = '0;
      start_a = last_r;
    end
  end

  assign el_inc = el_a + 1'b1;

  always_comb begin
    ph_n       = ph_a;
    el_n       = el_a;
    dur_sel    = dur_att;
    ramp_go    = 1'b0;
    lvl_direct = '0;
    from_n     = start_a;
    to_n       = FULL_SCALE;
    unique case (ph_a)
      PH_ATTACK: begin
        dur_sel = dur_att;
        if (el_a >= dur_att) begin
          ph_n       = PH_DECAY;
          el_n       = '0;
          lvl_direct = FULL_SCALE;
        end else begin
          el_n    = el_inc;
          ramp_go = 1'b1;
        end
      end
      PH_DECAY: begin
        dur_sel = dur_dec;
        from_n  = FULL_SCALE;
        to_n    = sust_eff;
        if (el_a >= dur_dec) begin
          ph_n       = PH_SUSTAIN;
          lvl_direct = sust_eff;
        end else begin
          el_n    = el_inc;
          ramp_go = 1'b1;
        end
      end
      PH_SUSTAIN: begin
        lvl_direct = sust_eff;
      end
      PH_RELEASE: begin
        dur_sel = dur_rel;
        to_n    = '0;
        if (el_a >= dur_rel) begin
          ph_n = PH_OFF;
        end else begin
          el_n    = el_inc;
          ramp_go = 1'b1;
        end
      end
      default: begin
        lvl_direct = '0;
      end
    endcase
  end

  // --------------------------------------------------------------------------
  // Shared arithmetic: divider step, multiply, final add
  // --------------------------------------------------------------------------
  logic [REM_W-1:0] trial, rem_step;
  logic             ge;
  logic signed [LEVEL_W:0]   diff;
  logic signed [PROD_W-1:0]  prod_w, sum_w;

  // First step compares the numerator's integer part, later steps shift in 0
  assign trial    = (cnt_r == '0) ? rem_r : {rem_r[REM_W-2:0], 1'b0};
  assign ge       = (trial >= {1'b0, dur_r});
  assign rem_step = ge ? (trial - {1'b0, dur_r}) : trial;

  assign diff   = $signed({1'b0, to_r}) - $signed({1'b0, from_r});
  assign prod_w = $signed({1'b0, quo_r}) * diff;
  // Arithmetic shift gives the floor for a falling ramp
  assign sum_w  = PROD_W'($signed({1'b0, from_r})) + (prod_r >>> FRAC_W);

  // --------------------------------------------------------------------------
  // Sequencer next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: if (in_acc) state_nxt = ramp_go ? ST_DIV : ST_FIN;
      ST_DIV:  if (cnt_r == CNT_LAST) state_nxt = ST_MUL;
      ST_MUL:  state_nxt = ST_ADD;
      ST_ADD:  state_nxt = ST_FIN;
      ST_FIN:  if (out_free) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    in_ready  = (state_r == ST_IDLE);
    cfg_ready = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      attack_r  <= '0;
      decay_r   <= '0;
      release_r <= '0;
      sustain_r <= FULL_SCALE;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_ATTACK:  attack_r  <= cfg_data[CFG_TICK_W-1:0];
        REG_DECAY:   decay_r   <= cfg_data[CFG_TICK_W-1:0];
        REG_RELEASE: release_r <= cfg_data[CFG_TICK_W-1:0];
        REG_SUSTAIN: sustain_r <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // Envelope state: phase and tick count move at accept, level at finish
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_OFF;
      el_r    <= '0;
      start_r <= '0;
      last_r  <= '0;
    end else begin
      if (in_acc) begin
        phase_r <= ph_n;
        el_r    <= el_n;
        start_r <= start_a;
      end
      if (state_r == ST_FIN && out_free) begin
        last_r <= lvl_r;
      end
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          cnt_r  <= '0;
          rem_r  <= {1'b0, el_n};
          quo_r  <= '0;
          dur_r  <= dur_sel;
          from_r <= from_n;
          to_r   <= to_n;
          lvl_r  <= lvl_direct;
        end
      end
      ST_DIV: begin
        cnt_r <= cnt_r + 1'b1;
        rem_r <= rem_step;
        quo_r <= {quo_r[QUO_W-2:0], ge};
      end
      ST_MUL: prod_r <= prod_w;
      ST_ADD: lvl_r  <= sum_w[LEVEL_W-1:0];
      default: ;
    endcase
  end

  // Output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == ST_FIN && out_free) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == ST_FIN && out_free) begin
      out_level_r <= lvl_r;
      out_phase_r <= phase_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_level = out_level_r;
  assign out_phase = out_phase_r;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_level <= FULL_SCALE)
    else $error("envelope level above full scale");

  a_off_is_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_phase == PH_OFF) |-> out_level == '0)
    else $error("nonzero level in off phase");

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("accepted a transaction while busy");

  a_div_to_mul: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_DIV && cnt_r == CNT_LAST) |=> state_r == ST_MUL)
    else $error("divider did not hand off to multiply");

endmodule

`default_nettype wire
